// File: src/paired_fifo_matcher_defines.svh
`ifndef PAIRED_FIFO_MATCHER_DEFINES_SVH
`define PAIRED_FIFO_MATCHER_DEFINES_SVH

// check that holds in the same cycle as the condition
`define PFM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("paired fifo matcher check failed");

// check that holds in the cycle after the condition
`define PFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("paired fifo matcher check failed");

`endif

// File: src/pfm_pkg.sv
`timescale 1ns / 1ps

package pfm_pkg;

   localparam int REQ_DEPTH_DEF = 16;
   localparam int SRV_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF   = 16;

   localparam int ACTION_W = 2;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_ADD_REQ = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_SRV = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MATCH   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CANCEL  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      QOP_PUSH   = 2'd0,
      QOP_POP    = 2'd1,
      QOP_CANCEL = 2'd2
   } q_op_type;

   typedef struct packed {
      logic     start;
      q_op_type op;
   } q_cmd_type;

endpackage

// File: src/pfm_queue.sv
`timescale 1ns / 1ps

module pfm_queue #(
   parameter int DEPTH = pfm_pkg::REQ_DEPTH_DEF,
   parameter int WIDTH = pfm_pkg::ID_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pfm_pkg::q_cmd_type           cmd,
   input  logic [WIDTH-1:0]             id,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         done,
   output logic [WIDTH-1:0]             rd_id
);
   import pfm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      Q_IDLE = 3'b001,
      Q_POP  = 3'b010,
      Q_SCAN = 3'b100
   } q_state_type;

   // circular buffer, oldest word at head
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   q_state_type state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_off_ff, rd_off_in;
   logic [CW-1:0]    wr_off_ff, wr_off_in;
   logic             scan_vld_ff, scan_vld_in;
   logic [WIDTH-1:0] id_ff, id_in;

   logic             we, re;
   logic [AW-1:0]    waddr, raddr;
   logic [WIDTH-1:0] wdata;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return AW'(s);
   endfunction

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      rd_off_in   = rd_off_ff;
      wr_off_in   = wr_off_ff;
      scan_vld_in = 1'b0;
      id_in       = id_ff;
      we          = 1'b0;
      re          = 1'b0;
      waddr       = wrap(head_ff, count_ff);
      raddr       = head_ff;
      wdata       = id;
      done        = 1'b0;
      case (state_ff)
         Q_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  QOP_PUSH: begin
                     we       = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  QOP_POP: begin
                     re       = 1'b1;
                     state_in = Q_POP;
                  end
                  QOP_CANCEL: begin
                     id_in     = id;
                     rd_off_in = '0;
                     wr_off_in = '0;
                     state_in  = Q_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         Q_POP: begin
            done     = 1'b1;
            head_in  = wrap(head_ff, CW'(1));
            count_in = count_ff - CW'(1);
            state_in = Q_IDLE;
         end
         Q_SCAN: begin
            // read one entry a cycle, write survivors back packed towards the head
            if (rd_off_ff < count_ff) begin
               re          = 1'b1;
               raddr       = wrap(head_ff, rd_off_ff);
               rd_off_in   = rd_off_ff + CW'(1);
               scan_vld_in = 1'b1;
            end
            if (scan_vld_ff && (rd_data_ff != id_ff)) begin
               we        = 1'b1;
               waddr     = wrap(head_ff, wr_off_ff);
               wdata     = rd_data_ff;
               wr_off_in = wr_off_ff + CW'(1);
            end
            if ((rd_off_ff == count_ff) && !scan_vld_ff) begin
               done     = 1'b1;
               count_in = wr_off_ff;
               state_in = Q_IDLE;
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= Q_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         rd_off_ff   <= '0;
         wr_off_ff   <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         rd_off_ff   <= rd_off_in;
         wr_off_ff   <= wr_off_in;
         scan_vld_ff <= scan_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign count = count_ff;
   assign rd_id = rd_data_ff;

endmodule

// File: src/paired_fifo_matcher.sv
`timescale 1ns / 1ps
`include "paired_fifo_matcher_defines.svh"

// Two first-in first-out queues of ids, requesters and servers, each held in a
// circular buffer with one read and one write port. Every word taken on req_
// gives exactly one word on rsp_. An add appends the id or, when that queue is
// full, drops it and reports full; it is accepted and its result is registered
// the cycle after. A match with an empty queue is answered the same way; a
// match that pops a pair waits until both heads are read from memory. A cancel
// walks the requester buffer one entry per cycle, writing survivors back in
// order. A new word is taken once the previous one has finished and the result
// register is free or being emptied. Ids keep the low ID_BITS bits (at most 16).

module paired_fifo_matcher #(
   parameter int REQUESTER_DEPTH = pfm_pkg::REQ_DEPTH_DEF,
   parameter int SERVER_DEPTH    = pfm_pkg::SRV_DEPTH_DEF,
   parameter int ID_BITS         = pfm_pkg::ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // id_value
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // server_id, requester_id
   output logic [2:0]  rsp_tuser    // status, matched
);
   import pfm_pkg::*;

   localparam int KW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int RCW = $clog2(REQUESTER_DEPTH+1);
   localparam int SCW = $clog2(SERVER_DEPTH+1);

   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_WAIT = 2'b10
   } t_state_type;

   t_state_type state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                matched_ff, matched_in;
   logic [ID_W-1:0]     srv_id_ff, srv_id_in;
   logic [ID_W-1:0]     rq_id_ff, rq_id_in;

   q_cmd_type           rq_cmd, sv_cmd;
   logic [KW-1:0]       in_id;
   logic [RCW-1:0]      rq_count;
   logic [SCW-1:0]      sv_count;
   logic                rq_done, sv_done;
   logic [KW-1:0]       rq_rd_id, sv_rd_id;
   logic                accept;
   logic [ACTION_W-1:0] in_action;

   assign in_action  = req_tuser;
   assign in_id      = req_tdata[KW-1:0];
   assign req_tready = (state_ff == T_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   pfm_queue #(
      .DEPTH (REQUESTER_DEPTH),
      .WIDTH (KW)
   ) u_rq_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (rq_cmd),
      .id    (in_id),
      .count (rq_count),
      .done  (rq_done),
      .rd_id (rq_rd_id)
   );

   pfm_queue #(
      .DEPTH (SERVER_DEPTH),
      .WIDTH (KW)
   ) u_sv_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (sv_cmd),
      .id    (in_id),
      .count (sv_count),
      .done  (sv_done),
      .rd_id (sv_rd_id)
   );

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      status_in     = status_ff;
      matched_in    = matched_ff;
      srv_id_in     = srv_id_ff;
      rq_id_in      = rq_id_ff;
      rq_cmd        = '{start: 1'b0, op: QOP_PUSH};
      sv_cmd        = '{start: 1'b0, op: QOP_PUSH};
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               action_in  = in_action;
               status_in  = ST_OK;
               matched_in = 1'b0;
               srv_id_in  = '0;
               rq_id_in   = '0;
               case (in_action)
                  ACT_ADD_REQ: begin
                     rsp_tvalid_in = 1'b1;
                     if (rq_count == RCW'(REQUESTER_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        rq_cmd = '{start: 1'b1, op: QOP_PUSH};
                     end
                  end
                  ACT_ADD_SRV: begin
                     rsp_tvalid_in = 1'b1;
                     if (sv_count == SCW'(SERVER_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        sv_cmd = '{start: 1'b1, op: QOP_PUSH};
                     end
                  end
                  ACT_MATCH: begin
                     if ((rq_count == '0) || (sv_count == '0)) begin
                        rsp_tvalid_in = 1'b1;
                        status_in     = ST_EMPTY;
                     end else begin
                        rq_cmd   = '{start: 1'b1, op: QOP_POP};
                        sv_cmd   = '{start: 1'b1, op: QOP_POP};
                        state_in = T_WAIT;
                     end
                  end
                  ACT_CANCEL: begin
                     rq_cmd   = '{start: 1'b1, op: QOP_CANCEL};
                     state_in = T_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         T_WAIT: begin
            // both pops finish together, so the requester side paces the wait
            if (rq_done) begin
               rsp_tvalid_in = 1'b1;
               state_in      = T_IDLE;
               if (action_ff == ACT_MATCH) begin
                  matched_in = 1'b1;
                  srv_id_in  = ID_W'(sv_rd_id);
                  rq_id_in   = ID_W'(rq_rd_id);
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      status_ff  <= status_in;
      matched_ff <= matched_in;
      srv_id_ff  <= srv_id_in;
      rq_id_ff   <= rq_id_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rq_id_ff, srv_id_ff};
   assign rsp_tuser  = {matched_ff, status_ff};

   `PFM_ASSERT_NOW(a_rq_count_bound, clock, reset, 1'b1, rq_count <= RCW'(REQUESTER_DEPTH))
   `PFM_ASSERT_NOW(a_no_accept_busy, clock, reset, state_ff == T_WAIT, !req_tready)
   `PFM_ASSERT_NEXT(a_add_answers, clock, reset,
      accept && ((in_action == ACT_ADD_REQ) || (in_action == ACT_ADD_SRV)), rsp_tvalid)
   `PFM_ASSERT_NEXT(a_wait_finishes, clock, reset,
      (state_ff == T_WAIT) && rq_done, (state_ff == T_IDLE) && rsp_tvalid)
   `PFM_ASSERT_NOW(a_pops_aligned, clock, reset,
      (state_ff == T_WAIT) && (action_ff == ACT_MATCH), rq_done == sv_done)

endmodule
